>>> src/tdor_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the torus dimension-order route block
package tdor_pkg;

    localparam int COORD_BITS = 8;
    localparam int VC_BITS    = 4;
    localparam int RADIX_BITS = COORD_BITS + 1;
    localparam int VCCNT_BITS = VC_BITS + 1;
    localparam int DIM_BITS   = 2;
    localparam int PORT_BITS  = 3;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    localparam logic [DIM_BITS-1:0] DIM_X = 2'd0;
    localparam logic [DIM_BITS-1:0] DIM_Y = 2'd1;
    localparam logic [DIM_BITS-1:0] DIM_Z = 2'd2;

    // arrival ports at or above this value count as host injection
    localparam logic [PORT_BITS-1:0] PORT_HOST = 3'd6;

    localparam logic [2:0] REG_RING_RADIX    = 3'd0;
    localparam logic [2:0] REG_ALLOW_REORDER = 3'd1;
    localparam logic [2:0] REG_LOCAL_X       = 3'd2;
    localparam logic [2:0] REG_LOCAL_Y       = 3'd3;
    localparam logic [2:0] REG_LOCAL_Z       = 3'd4;
    localparam logic [2:0] REG_ARRIVAL_PORT  = 3'd5;
    localparam logic [2:0] REG_VC_COUNT      = 3'd6;

    localparam logic [VCCNT_BITS-1:0] VC_COUNT_RESET = 5'd2;

    typedef struct packed {
        logic [RADIX_BITS-1:0] ring_radix;
        logic                  allow_reorder;
        logic [COORD_BITS-1:0] local_x;
        logic [COORD_BITS-1:0] local_y;
        logic [COORD_BITS-1:0] local_z;
        logic [PORT_BITS-1:0]  arrival_port;
        logic [VCCNT_BITS-1:0] vc_count;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] dest_x;
        logic [COORD_BITS-1:0] dest_y;
        logic [COORD_BITS-1:0] dest_z;
        logic [VC_BITS-1:0]    in_vc;
    } t_flit;

    typedef struct packed {
        logic                to_host;
        logic [DIM_BITS-1:0] out_dim;
        logic                out_dir;
        logic [VC_BITS-1:0]  out_vc;
        logic                vc_error;
    } t_route;

endpackage

>>> src/tdor_cfg.sv
`timescale 1ns / 1ps
// apb-style configuration register file
module tdor_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tdor_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [tdor_pkg::DATA_BITS-1:0]   pwdata,
    output logic [tdor_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready,
    output tdor_pkg::t_cfg                   o_cfg
);

    tdor_pkg::t_cfg r_cfg;
    tdor_pkg::t_cfg n_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[tdor_pkg::ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                tdor_pkg::REG_RING_RADIX:
                    n_cfg.ring_radix = pwdata[tdor_pkg::RADIX_BITS-1:0];
                tdor_pkg::REG_ALLOW_REORDER:
                    n_cfg.allow_reorder = pwdata[0];
                tdor_pkg::REG_LOCAL_X:
                    n_cfg.local_x = pwdata[tdor_pkg::COORD_BITS-1:0];
                tdor_pkg::REG_LOCAL_Y:
                    n_cfg.local_y = pwdata[tdor_pkg::COORD_BITS-1:0];
                tdor_pkg::REG_LOCAL_Z:
                    n_cfg.local_z = pwdata[tdor_pkg::COORD_BITS-1:0];
                tdor_pkg::REG_ARRIVAL_PORT:
                    n_cfg.arrival_port = pwdata[tdor_pkg::PORT_BITS-1:0];
                tdor_pkg::REG_VC_COUNT:
                    n_cfg.vc_count = pwdata[tdor_pkg::VCCNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            tdor_pkg::REG_RING_RADIX:
                prdata[tdor_pkg::RADIX_BITS-1:0] = r_cfg.ring_radix;
            tdor_pkg::REG_ALLOW_REORDER:
                prdata[0] = r_cfg.allow_reorder;
            tdor_pkg::REG_LOCAL_X:
                prdata[tdor_pkg::COORD_BITS-1:0] = r_cfg.local_x;
            tdor_pkg::REG_LOCAL_Y:
                prdata[tdor_pkg::COORD_BITS-1:0] = r_cfg.local_y;
            tdor_pkg::REG_LOCAL_Z:
                prdata[tdor_pkg::COORD_BITS-1:0] = r_cfg.local_z;
            tdor_pkg::REG_ARRIVAL_PORT:
                prdata[tdor_pkg::PORT_BITS-1:0] = r_cfg.arrival_port;
            tdor_pkg::REG_VC_COUNT:
                prdata[tdor_pkg::VCCNT_BITS-1:0] = r_cfg.vc_count;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring_radix    <= '0;
            r_cfg.allow_reorder <= 1'b0;
            r_cfg.local_x       <= '0;
            r_cfg.local_y       <= '0;
            r_cfg.local_z       <= '0;
            r_cfg.arrival_port  <= tdor_pkg::PORT_HOST;
            r_cfg.vc_count      <= tdor_pkg::VC_COUNT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> src/tdor_route.sv
`timescale 1ns / 1ps
// route computation: dimension pick, direction, dateline vc
module tdor_route (
    input  tdor_pkg::t_cfg   i_cfg,
    input  tdor_pkg::t_flit  i_flit,
    input  logic             i_toggle,
    output tdor_pkg::t_route o_route,
    output logic             o_toggle_flip
);

    logic                                is_host;
    logic [tdor_pkg::DIM_BITS-1:0]       dim;
    logic [tdor_pkg::COORD_BITS-1:0]     lc;
    logic [tdor_pkg::COORD_BITS-1:0]     dc;
    logic                                injecting;
    logic [tdor_pkg::DIM_BITS-1:0]       in_dim;
    logic                                same_dim;
    logic                                torus;
    logic [tdor_pkg::COORD_BITS:0]       delta;
    logic [tdor_pkg::COORD_BITS-1:0]     mag;
    logic [tdor_pkg::COORD_BITS-1:0]     half;
    logic                                tie;
    logic                                pos;
    logic                                dir;
    logic                                dateline;
    logic [tdor_pkg::VCCNT_BITS-1:0]     vc_full;

    // first differing dimension in x, y, z order
    always_comb begin
        is_host = 1'b0;
        dim     = tdor_pkg::DIM_X;
        lc      = i_cfg.local_x;
        dc      = i_flit.dest_x;
        priority if (i_cfg.local_x != i_flit.dest_x) begin
            dim = tdor_pkg::DIM_X;
        end else if (i_cfg.local_y != i_flit.dest_y) begin
            dim = tdor_pkg::DIM_Y;
            lc  = i_cfg.local_y;
            dc  = i_flit.dest_y;
        end else if (i_cfg.local_z != i_flit.dest_z) begin
            dim = tdor_pkg::DIM_Z;
            lc  = i_cfg.local_z;
            dc  = i_flit.dest_z;
        end else begin
            is_host = 1'b1;
        end
    end

    assign injecting = i_cfg.arrival_port >= tdor_pkg::PORT_HOST;
    assign in_dim    = i_cfg.arrival_port[tdor_pkg::PORT_BITS-1:1];
    assign same_dim  = !injecting && (in_dim == dim);
    assign torus     = i_cfg.ring_radix != '0;

    // shorter way round the ring, ties by toggle or local parity
    assign delta = {1'b0, dc} - {1'b0, lc};
    assign mag   = delta[tdor_pkg::COORD_BITS] ? (lc - dc) : delta[tdor_pkg::COORD_BITS-1:0];
    assign half  = i_cfg.ring_radix[tdor_pkg::RADIX_BITS-1:1];
    assign tie   = torus && (mag == half);

    always_comb begin
        pos = (dc > lc);
        if (torus) begin
            if (mag == half) begin
                pos = i_cfg.allow_reorder ? i_toggle : lc[0];
            end else if (mag > half) begin
                pos = ~pos;
            end
        end
    end

    assign dir = same_dim ? ~i_cfg.arrival_port[0] : pos;

    assign dateline = ((lc == '0) && !dir) ||
                      (({1'b0, lc} == (i_cfg.ring_radix - 1'b1)) && dir);

    always_comb begin
        vc_full = {1'b0, i_flit.in_vc};
        if (torus) begin
            if (!injecting && (in_dim != dim)) begin
                vc_full = {1'b0, i_flit.in_vc[tdor_pkg::VC_BITS-1:1], 1'b0};
            end else if (dateline) begin
                vc_full = {1'b0, i_flit.in_vc} + 1'b1;
            end
        end
    end

    always_comb begin
        if (is_host) begin
            o_route.to_host  = 1'b1;
            o_route.out_dim  = tdor_pkg::DIM_X;
            o_route.out_dir  = 1'b0;
            o_route.out_vc   = i_flit.in_vc;
            o_route.vc_error = 1'b0;
        end else begin
            o_route.to_host  = 1'b0;
            o_route.out_dim  = dim;
            o_route.out_dir  = dir;
            o_route.out_vc   = vc_full[tdor_pkg::VC_BITS-1:0];
            o_route.vc_error = vc_full >= i_cfg.vc_count;
        end
    end

    assign o_toggle_flip = !is_host && !same_dim && tie && i_cfg.allow_reorder;

endmodule

>>> src/torus_dimension_order_route_top.sv
`timescale 1ns / 1ps
// top level of the torus dimension-order route block
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+---------------------------------------
//  in       | i_in_valid / o_in_ready         | i_dest_x, i_dest_y, i_dest_z, i_in_vc
//  out      | o_out_valid / i_out_ready       | o_to_host, o_out_dim, o_out_dir,
//           |                                 | o_out_vc, o_vc_error
//  config   | psel, penable, pwrite / pready  | paddr, pwdata, prdata
//
// one transfer per cycle sustained while i_out_ready is held high; a flit's result reaches
// the outputs through the input register, route logic and result register
// synchronous active-low reset empties both registers and clears the tie toggle
// a stalled output holds its result; the input register still advances into
// the result register in the same cycle the result is taken
module torus_dimension_order_route_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tdor_pkg::ADDR_BITS-1:0] paddr,
    input  logic [tdor_pkg::DATA_BITS-1:0] pwdata,
    output logic [tdor_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tdor_pkg::COORD_BITS-1:0] i_dest_x,
    input  logic [tdor_pkg::COORD_BITS-1:0] i_dest_y,
    input  logic [tdor_pkg::COORD_BITS-1:0] i_dest_z,
    input  logic [tdor_pkg::VC_BITS-1:0]   i_in_vc,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_to_host,
    output logic [tdor_pkg::DIM_BITS-1:0]  o_out_dim,
    output logic                           o_out_dir,
    output logic [tdor_pkg::VC_BITS-1:0]   o_out_vc,
    output logic                           o_vc_error
);

    tdor_pkg::t_cfg   cfg;
    tdor_pkg::t_flit  r_flit;
    tdor_pkg::t_route route;
    tdor_pkg::t_route r_route;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             r_toggle;
    logic             toggle_flip;
    logic             out_load;
    logic             advance;
    logic             in_xfer;

    tdor_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tdor_route u_route (
        .i_cfg         (cfg),
        .i_flit        (r_flit),
        .i_toggle      (r_toggle),
        .o_route       (route),
        .o_toggle_flip (toggle_flip)
    );

    assign out_load   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_load;
    assign o_in_ready = !r_in_valid || out_load;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_toggle    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (advance && toggle_flip) begin
                r_toggle <= ~r_toggle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_flit.dest_x <= i_dest_x;
            r_flit.dest_y <= i_dest_y;
            r_flit.dest_z <= i_dest_z;
            r_flit.in_vc  <= i_in_vc;
        end
        if (advance) begin
            r_route <= route;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_to_host   = r_route.to_host;
    assign o_out_dim   = r_route.out_dim;
    assign o_out_dir   = r_route.out_dir;
    assign o_out_vc    = r_route.out_vc;
    assign o_vc_error  = r_route.vc_error;

endmodule
